### design/u8ld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8ld_pkg;

  // Widths of the payload fields
  localparam int unsigned CP_W   = 22;
  localparam int unsigned BYTE_W = 8;

  // Substitute code point for malformed input
  localparam logic [CP_W-1:0] REPLACEMENT = 22'h00FFFD;

  // At most this many results leave for one input byte
  localparam logic [2:0] MAX_RES = 3'd4;

  // Byte class thresholds
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;

  // One decoded result before its run flags are known
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
  } res_t;

  // Controller state, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_STEP  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take the input byte into the queue
    logic step;       // decode one queued byte, or close a cut sequence
    logic take;       // move the step result into the pending slot
    logic push;       // pending result to output, not last of run
    logic push_last;  // pending result to output as last of run
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;       // nothing left to decode for this byte
    logic step_res;   // the next step yields a result
    logic pend_valid; // a result waits in the pending slot
    logic rc_full;    // result limit reached for this byte
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

### design/u8ld_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8ld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

### design/u8ld_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8ld_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] code_point;
  logic        replaced;
  logic        last_of_run;
  logic        string_done;

  modport source (output valid, output code_point, output replaced,
                  output last_of_run, output string_done, input ready);
  modport sink   (input valid, input code_point, input replaced,
                  input last_of_run, input string_done, output ready);
endinterface

`default_nettype wire

### design/u8ld_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module u8ld_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire u8ld_pkg::stat_t stat,
  output u8ld_pkg::cmd_t      cmd
);

  u8ld_pkg::state_t state_r, state_nxt;
  logic             advance;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u8ld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A step that makes a result must be able to shift the pending one out
  assign advance = !stat.step_res || stat.rc_full || !stat.pend_valid || stat.out_free;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      u8ld_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = u8ld_pkg::ST_STEP;
        end
      end
      u8ld_pkg::ST_STEP: begin
        if (stat.done) begin
          state_nxt = stat.pend_valid ? u8ld_pkg::ST_FLUSH : u8ld_pkg::ST_IDLE;
        end else if (advance) begin
          cmd.step = 1'b1;
          if (stat.step_res && !stat.rc_full) begin
            cmd.take = 1'b1;
            cmd.push = stat.pend_valid;
          end
        end
      end
      u8ld_pkg::ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = u8ld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = u8ld_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/u8ld_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module u8ld_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      in_byte,
  input  wire logic            end_of_string,
  input  wire u8ld_pkg::cmd_t  cmd,
  output u8ld_pkg::stat_t      stat,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [21:0]          out_code_point,
  output logic                 out_replaced,
  output logic                 out_last_of_run,
  output logic                 out_string_done
);

  // Byte queue: the input byte plus any bytes handed back for replay
  logic [2:0][7:0] q_r, q_nxt;
  logic [1:0]      qn_r, qn_nxt;
  logic            eos_r, eos_nxt;

  // Open sequence
  logic            open_r, open_nxt;
  logic [7:0]      lead_r, lead_nxt;
  logic [1:0][7:0] held_r, held_nxt;
  logic [1:0]      hc_r, hc_nxt;
  logic [21:0]     acc_r, acc_nxt;

  // Pending result and output register
  u8ld_pkg::res_t  pend_r, pend_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic [2:0]      rc_r, rc_nxt;
  logic [21:0]     ocp_r, ocp_nxt;
  logic            orep_r, orep_nxt;
  logic            olast_r, olast_nxt;
  logic            odone_r, odone_nxt;
  logic            ovalid_r, ovalid_nxt;

  // Step outcome
  logic            q_empty;
  logic [7:0]      b;
  logic            cut;
  logic [1:0]      need;
  logic [1:0]      hc_inc;
  logic [21:0]     acc_f;
  logic [21:0]     acc_start;
  logic [2:0][7:0] rq;
  logic            res_has;
  u8ld_pkg::res_t  res;

  assign q_empty = (qn_r == 2'd0);
  assign b       = q_r[0];
  assign cut     = open_r && !b[7];

  // Followers needed by the open lead
  always_comb begin
    if (lead_r >= u8ld_pkg::LEAD4_MIN) begin
      need = 2'd3;
    end else if (lead_r >= u8ld_pkg::LEAD3_MIN) begin
      need = 2'd2;
    end else begin
      need = 2'd1;
    end
  end

  // Payload of a new lead, and one six-bit shift with the follower added
  assign acc_start = (b >= u8ld_pkg::LEAD3_MIN) ? {18'd0, b[3:0]} : {17'd0, b[4:0]};
  assign acc_f     = {acc_r[15:0], 6'd0} + {15'd0, b[6:0]};
  assign hc_inc    = hc_r + 2'd1;

  // Held bytes in front of the remaining queue
  always_comb begin
    case (hc_r)
      2'd1:    rq = {q_r[1], q_r[0], held_r[0]};
      2'd2:    rq = {q_r[0], held_r[1], held_r[0]};
      default: rq = q_r;
    endcase
  end

  // Result of the next step
  always_comb begin
    res_has = 1'b0;
    res     = '{code_point: u8ld_pkg::REPLACEMENT, replaced: 1'b1};
    if (q_empty) begin
      res_has = 1'b1;
    end else if (cut) begin
      res_has = 1'b1;
    end else if (!open_r) begin
      if (!b[7]) begin
        res_has = 1'b1;
        res     = '{code_point: {14'd0, b}, replaced: 1'b0};
      end else if (!b[6]) begin
        res_has = 1'b1;
      end
    end else if (hc_inc >= need) begin
      res_has = 1'b1;
      res     = '{code_point: acc_f, replaced: 1'b0};
    end
  end

  // Queue and sequence next state
  always_comb begin
    q_nxt    = q_r;
    qn_nxt   = qn_r;
    eos_nxt  = eos_r;
    open_nxt = open_r;
    lead_nxt = lead_r;
    held_nxt = held_r;
    hc_nxt   = hc_r;
    acc_nxt  = acc_r;
    if (cmd.load) begin
      q_nxt[0] = in_byte;
      qn_nxt   = 2'd1;
      eos_nxt  = end_of_string;
    end else if (cmd.step) begin
      if (q_empty) begin
        // end of string with a sequence open: replay its held bytes
        q_nxt    = {q_r[2], held_r[1], held_r[0]};
        qn_nxt   = hc_r;
        open_nxt = 1'b0;
        hc_nxt   = 2'd0;
        lead_nxt = 8'd0;
      end else if (cut) begin
        // low byte breaks the sequence: held bytes go back ahead of it
        q_nxt    = rq;
        qn_nxt   = 2'(hc_r + qn_r);
        open_nxt = 1'b0;
        hc_nxt   = 2'd0;
        lead_nxt = 8'd0;
      end else begin
        q_nxt  = {q_r[2], q_r[2], q_r[1]};
        qn_nxt = qn_r - 2'd1;
        if (!open_r) begin
          if (b[7] && b[6]) begin
            open_nxt = 1'b1;
            lead_nxt = b;
            hc_nxt   = 2'd0;
            acc_nxt  = acc_start;
          end
        end else begin
          if (!hc_r[1]) begin
            held_nxt[hc_r[0]] = b;
          end
          hc_nxt  = hc_inc;
          acc_nxt = acc_f;
          if (hc_inc >= need) begin
            open_nxt = 1'b0;
            hc_nxt   = 2'd0;
            lead_nxt = 8'd0;
          end
        end
      end
    end
  end

  // Pending slot and output register
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    rc_nxt         = rc_r;
    ocp_nxt        = ocp_r;
    orep_nxt       = orep_r;
    olast_nxt      = olast_r;
    odone_nxt      = odone_r;
    ovalid_nxt     = ovalid_r && !out_ready;
    if (cmd.load) begin
      rc_nxt = 3'd0;
    end
    if (cmd.push || cmd.push_last) begin
      ocp_nxt    = pend_r.code_point;
      orep_nxt   = pend_r.replaced;
      olast_nxt  = cmd.push_last;
      odone_nxt  = cmd.push_last && eos_r;
      ovalid_nxt = 1'b1;
    end
    if (cmd.push_last) begin
      pend_valid_nxt = 1'b0;
    end
    if (cmd.take) begin
      pend_nxt       = res;
      pend_valid_nxt = 1'b1;
      rc_nxt         = rc_r + 3'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r         <= 2'd0;
      eos_r        <= 1'b0;
      open_r       <= 1'b0;
      lead_r       <= 8'd0;
      hc_r         <= 2'd0;
      pend_valid_r <= 1'b0;
      rc_r         <= 3'd0;
      ovalid_r     <= 1'b0;
    end else begin
      qn_r         <= qn_nxt;
      eos_r        <= eos_nxt;
      open_r       <= open_nxt;
      lead_r       <= lead_nxt;
      hc_r         <= hc_nxt;
      pend_valid_r <= pend_valid_nxt;
      rc_r         <= rc_nxt;
      ovalid_r     <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    held_r  <= held_nxt;
    acc_r   <= acc_nxt;
    pend_r  <= pend_nxt;
    ocp_r   <= ocp_nxt;
    orep_r  <= orep_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  // Status
  assign stat.done       = q_empty && !(eos_r && open_r);
  assign stat.step_res   = res_has;
  assign stat.pend_valid = pend_valid_r;
  assign stat.rc_full    = (rc_r == u8ld_pkg::MAX_RES);
  assign stat.out_free   = !ovalid_r || out_ready;

  assign out_valid       = ovalid_r;
  assign out_code_point  = ocp_r;
  assign out_replaced    = orep_r;
  assign out_last_of_run = olast_r;
  assign out_string_done = odone_r;

endmodule

`default_nettype wire

### design/utf8_lenient_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Lenient UTF-8 decoder: one byte per input transfer, up to four code points out per
// byte, the last flagged last_of_run and, on the final byte of a string, string_done.
// A byte is taken in the idle state. The decode step then works through each queued
// byte, and closes each sequence that a low byte or the end of the string cuts (a
// cut hands the held bytes back for replay). A final step finds the queue empty,
// and a byte that yields results then hands over its final result from the pending
// slot. The input is not taken again until the step sequencer has finished with the
// current byte; back-pressure on the output stalls it.
// No clearing pass after reset.
module utf8_lenient_decoder_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  u8ld_in_if.sink   in_chan,
  u8ld_out_if.source out_chan
);

  u8ld_pkg::cmd_t  cmd;
  u8ld_pkg::stat_t stat;

  // Step sequencer
  u8ld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Byte queue, sequence state and result registers
  u8ld_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_chan.in_byte),
    .end_of_string   (in_chan.end_of_string),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_code_point  (out_chan.code_point),
    .out_replaced    (out_chan.replaced),
    .out_last_of_run (out_chan.last_of_run),
    .out_string_done (out_chan.string_done)
  );

endmodule

`default_nettype wire

### design/u8ld_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u8ld_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [21:0] code_point,
  input wire logic        replaced,
  input wire logic        last_of_run,
  input wire logic        string_done
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(replaced)
      && $stable(last_of_run) && $stable(string_done))
    else $error("result changed while stalled");

  // End of string only on the last result of a byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_done |-> last_of_run)
    else $error("string_done without last_of_run");

  // A substitution always carries the replacement character
  a_rep_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && replaced |-> code_point == 22'h00FFFD)
    else $error("substitute with wrong code point");

  // One byte in work at a time
  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a byte is in work");

endmodule

bind utf8_lenient_decoder_unit u8ld_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .code_point  (out_chan.code_point),
  .replaced    (out_chan.replaced),
  .last_of_run (out_chan.last_of_run),
  .string_done (out_chan.string_done)
);

`default_nettype wire
